### rtl/nwt_pkg.sv
// Shared types and codes for the name watch table.
// Used by every module of the block; no dependencies.
`default_nettype none
package nwt_pkg;

   localparam int CAPACITY_DEF   = 40;
   localparam int NAME_BYTES_DEF = 16;
   localparam int NAME_W         = 124;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
   localparam logic [2:0] ST_DUPLICATE  = 3'd2;
   localparam logic [2:0] ST_FULL       = 3'd3;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd4;

   typedef struct packed {
      logic [1:0]  cmd;
      logic        bad;
      logic [3:0]  len;
      logic [55:0] hi;
      logic [63:0] lo;
   } cmd_type;

endpackage
`default_nettype wire

### rtl/name_watch_table_core.sv
// Name watch table: up to CAPACITY names of 1 to NAME_BYTES-1 bytes with
// insert, remove and lookup. The sequencer walks each stored entry through
// the registered name memory with a single comparator, and starts a new
// command only once the last one has answered; bad-length and unused
// commands skip the walk. A stalled response holds the sequencer. A
// two-entry queue lets requests arrive while one runs.
`default_nettype none
module name_watch_table_core #(
   parameter int CAPACITY   = nwt_pkg::CAPACITY_DEF,
   parameter int NAME_BYTES = nwt_pkg::NAME_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [63:0] req_name_low,
   input  wire logic [55:0] req_name_high,
   input  wire logic [4:0]  req_name_len,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic             rsp_found,
   output logic [5:0]       rsp_slot,
   output logic [5:0]       rsp_entry_total
);

   logic                 push_valid, push_full, pop, q_not_empty;
   nwt_pkg::cmd_type     push_item, q_head;
   logic [CAPACITY-1:0]  occupied;
   logic [$clog2(CAPACITY+1)-1:0] used_count;

   nwt_front #(.NAME_BYTES(NAME_BYTES)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_cmd, .req_name_low,
      .req_name_high, .req_name_len, .push_valid, .push_full, .push_item
   );

   nwt_queue u_queue (
      .clock, .reset, .push(push_valid), .push_item, .full(push_full),
      .pop, .not_empty(q_not_empty), .head(q_head)
   );

   nwt_back #(.CAPACITY(CAPACITY)) u_back (
      .clock, .reset, .q_not_empty, .q_head, .q_pop(pop), .rsp_valid,
      .rsp_stall, .rsp_status, .rsp_found, .rsp_slot, .rsp_entry_total,
      .occupied, .used_count
   );

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_count <= ($clog2(CAPACITY+1))'(CAPACITY))
      else $error("entry count above capacity");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(occupied) == int'(used_count))
      else $error("entry count disagrees with occupied slots");

   a_found_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |->
      rsp_status == nwt_pkg::ST_OK || rsp_status == nwt_pkg::ST_DUPLICATE)
      else $error("found with a failing status");

endmodule
`default_nettype wire

### rtl/nwt_front.sv
// Front end: takes request beats, masks the name and checks its length.
// Uses nwt_pkg; feeds nwt_queue.
`default_nettype none
module nwt_front #(
   parameter int NAME_BYTES = nwt_pkg::NAME_BYTES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [1:0]       req_cmd,
   input  wire logic [63:0]      req_name_low,
   input  wire logic [55:0]      req_name_high,
   input  wire logic [4:0]       req_name_len,
   output logic                  push_valid,
   input  wire logic             push_full,
   output nwt_pkg::cmd_type      push_item
);

   logic             valid_ff, valid_in;
   nwt_pkg::cmd_type item_ff, item_in;
   logic [4:0]       len_cut;
   logic [3:0]       len4;
   logic             take;

   always_comb begin
      len_cut = req_name_len;
      if (req_cmd == nwt_pkg::CMD_LOOKUP && req_name_len >= 5'(NAME_BYTES - 1)) begin
         len_cut = 5'(NAME_BYTES - 1);
      end
      len4 = (len_cut > 5'd15) ? 4'd15 : len_cut[3:0];
      item_in.cmd = req_cmd;
      item_in.len = len4;
      item_in.bad = (req_cmd == nwt_pkg::CMD_INSERT || req_cmd == nwt_pkg::CMD_REMOVE) &&
                    (req_name_len == 5'd0 || req_name_len >= 5'(NAME_BYTES));
      for (int i = 0; i < 8; i++) begin
         item_in.lo[8*i +: 8] = (4'(i) < len4) ? req_name_low[8*i +: 8] : 8'd0;
      end
      for (int i = 0; i < 7; i++) begin
         item_in.hi[8*i +: 8] = (4'(i + 8) < len4) ? req_name_high[8*i +: 8] : 8'd0;
      end
   end

   assign req_stall  = valid_ff && push_full;
   assign take       = req_valid && !req_stall;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && !push_full) valid_in = 1'b0;
      if (take) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) item_ff <= item_in;
   end

endmodule
`default_nettype wire

### rtl/nwt_queue.sv
// Two-entry queue between the front end and the table sequencer.
// Uses nwt_pkg for the command type.
`default_nettype none
module nwt_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire nwt_pkg::cmd_type  push_item,
   output logic                   full,
   input  wire logic              pop,
   output logic                   not_empty,
   output nwt_pkg::cmd_type       head
);

   nwt_pkg::cmd_type slot_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push, do_pop;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
      if (do_push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule
`default_nettype wire

### rtl/nwt_back.sv
// Table sequencer: walks stored names with one comparator, then inserts,
// removes or reports. Holds name memory, free stack and response register.
`default_nettype none
module nwt_back #(
   parameter int CAPACITY = nwt_pkg::CAPACITY_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_not_empty,
   input  wire nwt_pkg::cmd_type  q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [2:0]             rsp_status,
   output logic                   rsp_found,
   output logic [5:0]             rsp_slot,
   output logic [5:0]             rsp_entry_total,
   output logic [CAPACITY-1:0]    occupied,
   output logic [$clog2(CAPACITY+1)-1:0] used_count
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
   localparam logic [IW-1:0] LAST_I = IW'(CAPACITY - 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [nwt_pkg::NAME_W-1:0] name_mem [CAPACITY];
   logic [IW-1:0]              stk_mem  [CAPACITY];

   logic [1:0]             st_ff, st_in;
   nwt_pkg::cmd_type       item_ff;
   logic [IW-1:0]          idx_ff;
   logic                   cmp_vld_ff;
   logic [IW-1:0]          cmp_idx_ff;
   logic [nwt_pkg::NAME_W-1:0] name_rd_ff;
   logic                   hit_ff;
   logic [IW-1:0]          hit_slot_ff;
   logic [CW-1:0]          used_ff, used_in;
   logic [CAPACITY-1:0]    valid_ff, valid_in;
   logic [CAPACITY-1:0]    stk_wr_ff;
   logic [IW-1:0]          stk_rd_ff, stk_addr_ff, stk_addr;
   logic                   stk_def_ff;
   logic [IW-1:0]          stk_val;
   logic                   rsp_valid_ff;
   logic [2:0]             status_ff, status_in;
   logic                   found_ff, found_in;
   logic [IW-1:0]          slot_ff, slot_in;
   logic                   match, finish, load;
   logic                   name_we, stk_we;
   logic [IW-1:0]          stk_wr_idx;

   assign match = cmp_vld_ff && valid_ff[cmp_idx_ff] &&
                  name_rd_ff == {item_ff.len, item_ff.hi, item_ff.lo};
   assign finish = st_ff == S_FINISH && !(rsp_valid_ff && rsp_stall);
   assign load   = st_ff == S_IDLE && q_not_empty;
   assign q_pop  = load;
   assign stk_addr   = LAST_I - used_ff[IW-1:0];
   assign stk_val    = stk_def_ff ? stk_rd_ff : LAST_I - stk_addr_ff;
   assign stk_wr_idx = IW'(CAP_C - used_ff);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE: begin
            if (load) begin
               st_in = (q_head.bad || q_head.cmd == nwt_pkg::CMD_UNUSED) ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN:   if (idx_ff == LAST_I) st_in = S_DRAIN;
         S_DRAIN:  st_in = S_FINISH;
         S_FINISH: if (finish) st_in = S_IDLE;
         default:  st_in = S_IDLE;
      endcase
   end

   always_comb begin
      status_in = nwt_pkg::ST_NOT_FOUND;
      found_in  = 1'b0;
      slot_in   = '0;
      used_in   = used_ff;
      valid_in  = valid_ff;
      name_we   = 1'b0;
      stk_we    = 1'b0;
      case (item_ff.cmd)
         nwt_pkg::CMD_INSERT: begin
            if (item_ff.bad) begin
               status_in = nwt_pkg::ST_BAD_LENGTH;
            end else if (hit_ff) begin
               status_in = nwt_pkg::ST_DUPLICATE;
               found_in  = 1'b1;
               slot_in   = hit_slot_ff;
            end else if (used_ff == CAP_C) begin
               status_in = nwt_pkg::ST_FULL;
            end else begin
               status_in         = nwt_pkg::ST_OK;
               slot_in           = stk_val;
               name_we           = 1'b1;
               valid_in[stk_val] = 1'b1;
               used_in           = used_ff + CW'(1);
            end
         end
         nwt_pkg::CMD_REMOVE: begin
            if (item_ff.bad) begin
               status_in = nwt_pkg::ST_BAD_LENGTH;
            end else if (hit_ff) begin
               status_in             = nwt_pkg::ST_OK;
               found_in              = 1'b1;
               slot_in               = hit_slot_ff;
               valid_in[hit_slot_ff] = 1'b0;
               stk_we                = 1'b1;
               used_in               = used_ff - CW'(1);
            end
         end
         nwt_pkg::CMD_LOOKUP: begin
            if (hit_ff) begin
               status_in = nwt_pkg::ST_OK;
               found_in  = 1'b1;
               slot_in   = hit_slot_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         used_ff      <= '0;
         valid_ff     <= '0;
         stk_wr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         idx_ff       <= '0;
      end else begin
         st_ff      <= st_in;
         cmp_vld_ff <= st_ff == S_SCAN;
         if (st_ff == S_SCAN) idx_ff <= idx_ff + IW'(1);
         if (load) begin
            idx_ff <= '0;
            hit_ff <= 1'b0;
         end else if (match && !hit_ff) begin
            hit_ff <= 1'b1;
         end
         rsp_valid_ff <= finish || (rsp_valid_ff && rsp_stall);
         if (finish) begin
            used_ff      <= used_in;
            valid_ff     <= valid_in;
            if (stk_we) stk_wr_ff[stk_wr_idx] <= 1'b1;
         end
      end
      if (load) item_ff <= q_head;
      if (match && !hit_ff) hit_slot_ff <= cmp_idx_ff;
      cmp_idx_ff  <= idx_ff;
      name_rd_ff  <= name_mem[idx_ff];
      stk_rd_ff   <= stk_mem[stk_addr];
      stk_def_ff  <= stk_wr_ff[stk_addr];
      stk_addr_ff <= stk_addr;
      if (finish) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         slot_ff   <= slot_in;
      end
      if (finish && name_we) name_mem[stk_val] <= {item_ff.len, item_ff.hi, item_ff.lo};
      if (finish && stk_we) stk_mem[stk_wr_idx] <= hit_slot_ff;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_slot        = 6'(slot_ff);
   assign rsp_entry_total = 6'(used_ff);
   assign occupied        = valid_ff;
   assign used_count      = used_ff;

endmodule
`default_nettype wire

### tb/sv/name_watch_table_checker.sv
// Checker for the name watch table: watches the request and response beats,
// predicts each response from its own table model, and counts mismatches.
// Depends on nwt_pkg for command and status codes.
`default_nettype none
module name_watch_table_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [63:0] req_name_low,
   input  wire logic [55:0] req_name_high,
   input  wire logic [4:0]  req_name_len,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [2:0]  rsp_status,
   input  wire logic        rsp_found,
   input  wire logic [5:0]  rsp_slot,
   input  wire logic [5:0]  rsp_entry_total,
   output int               error_count,
   output int               pending_count
);
   import nwt_pkg::*;

   localparam int SLOTS = CAPACITY_DEF;

   typedef struct packed {
      logic [2:0] status;
      logic       found;
      logic [5:0] slot;
      logic [5:0] entry_total;
   } reply_type;

   logic [63:0] name_lo_mem [SLOTS];
   logic [55:0] name_hi_mem [SLOTS];
   logic [3:0]  name_len_mem [SLOTS];
   logic        occupied [SLOTS];
   logic [5:0]  free_slots [SLOTS];
   int          free_depth;
   int          stored_names;
   reply_type   replies_due [$];

   assign pending_count = replies_due.size();

   function automatic int match_slot(logic [63:0] lo, logic [55:0] hi, logic [3:0] len);
      for (int i = 0; i < SLOTS; i++)
         if (occupied[i] && name_len_mem[i] == len && name_lo_mem[i] == lo &&
             name_hi_mem[i] == hi)
            return i;
      return -1;
   endfunction

   task automatic apply_command(logic [1:0] cmd, logic [63:0] lo_in, logic [55:0] hi_in,
                                logic [4:0] len_in);
      int        len;
      int        hit;
      logic [63:0] lo;
      logic [55:0] hi;
      reply_type r;
      len = len_in;
      r = '0;
      r.status = ST_NOT_FOUND;
      if (cmd == CMD_LOOKUP && len > NAME_BYTES_DEF - 1) len = NAME_BYTES_DEF - 1;
      lo = '0;
      hi = '0;
      for (int b = 0; b < 8; b++) if (b < len) lo[8*b +: 8] = lo_in[8*b +: 8];
      for (int b = 0; b < 7; b++) if (b + 8 < len) hi[8*b +: 8] = hi_in[8*b +: 8];
      if (cmd == CMD_INSERT || cmd == CMD_REMOVE) begin
         if (len == 0 || len >= NAME_BYTES_DEF) begin
            r.status = ST_BAD_LENGTH;
         end else begin
            hit = match_slot(lo, hi, len[3:0]);
            if (cmd == CMD_INSERT) begin
               if (hit >= 0) begin
                  r.status = ST_DUPLICATE;
                  r.found = 1'b1;
                  r.slot = hit[5:0];
               end else if (free_depth == 0) begin
                  r.status = ST_FULL;
               end else begin
                  free_depth--;
                  r.slot = free_slots[free_depth];
                  name_lo_mem[r.slot] = lo;
                  name_hi_mem[r.slot] = hi;
                  name_len_mem[r.slot] = len[3:0];
                  occupied[r.slot] = 1'b1;
                  stored_names++;
                  r.status = ST_OK;
               end
            end else if (hit >= 0) begin
               occupied[hit] = 1'b0;
               free_slots[free_depth] = hit[5:0];
               free_depth++;
               stored_names--;
               r.status = ST_OK;
               r.found = 1'b1;
               r.slot = hit[5:0];
            end
         end
      end else if (cmd == CMD_LOOKUP) begin
         hit = match_slot(lo, hi, len[3:0]);
         if (hit >= 0) begin
            r.status = ST_OK;
            r.found = 1'b1;
            r.slot = hit[5:0];
         end
      end
      r.entry_total = stored_names[5:0];
      replies_due.push_back(r);
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            occupied[i] = 1'b0;
            free_slots[i] = 6'(SLOTS - 1 - i);
         end
         free_depth = SLOTS;
         stored_names = 0;
         replies_due.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               $display("%0t: unexpected response beat status=%0d", $time, rsp_status);
               error_count++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           rsp_status);
                  error_count++;
               end
               if (rsp_found !== want.found) begin
                  $display("%0t: found expected %0d actual %0d", $time, want.found, rsp_found);
                  error_count++;
               end
               if (rsp_slot !== want.slot) begin
                  $display("%0t: slot expected %0d actual %0d", $time, want.slot, rsp_slot);
                  error_count++;
               end
               if (rsp_entry_total !== want.entry_total) begin
                  $display("%0t: entry_total expected %0d actual %0d", $time,
                           want.entry_total, rsp_entry_total);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            apply_command(req_cmd, req_name_low, req_name_high, req_name_len);
      end
   end
endmodule
`default_nettype wire

### tb/sv/name_watch_table_core_test.sv
// Testbench top for name_watch_table_core: drives directed and random
// insert/remove/lookup beats with random idling and gives the verdict.
// Depends on nwt_pkg, name_watch_table_core and name_watch_table_checker.
`default_nettype none
module name_watch_table_core_test;
   import nwt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = CMD_LOOKUP;
   logic [63:0] req_name_low = '0;
   logic [55:0] req_name_high = '0;
   logic [4:0]  req_name_len = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_found;
   logic [5:0]  rsp_slot;
   logic [5:0]  rsp_entry_total;
   int          error_count;
   int          pending_count;
   int          cycle_count = 0;
   bit          calm = 1'b0;

   logic [63:0] pool_lo [12];
   logic [55:0] pool_hi [12];
   logic [4:0]  pool_len [12];

   always #6 clock = ~clock;

   name_watch_table_core dut (.*);

   name_watch_table_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < 15);

   task automatic send_beat(logic [1:0] cmd, logic [63:0] lo, logic [55:0] hi,
                            logic [4:0] len);
      while (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_name_low <= lo;
      req_name_high <= hi;
      req_name_len <= len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_pool(int k);
      logic [1:0] cmd;
      logic [63:0] lo;
      logic [55:0] hi;
      int r;
      r = $urandom_range(99);
      cmd = (r < 45) ? CMD_INSERT : (r < 75) ? CMD_REMOVE : (r < 98) ? CMD_LOOKUP : CMD_UNUSED;
      lo = pool_lo[k];
      hi = pool_hi[k];
      // junk past the length must be ignored
      for (int b = 0; b < 15; b++)
         if (b >= pool_len[k] && $urandom_range(1)) begin
            if (b < 8) lo[8*b +: 8] = 8'($urandom);
            else hi[8*(b-8) +: 8] = 8'($urandom);
         end
      send_beat(cmd, lo, hi, pool_len[k]);
   endtask

   initial begin
      int n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_beat(CMD_INSERT, '0, '0, 5'd0);
      send_beat(CMD_INSERT, '1, '1, 5'd16);
      send_beat(CMD_INSERT, '1, '1, 5'd31);
      send_beat(CMD_INSERT, '1, '1, 5'd15);
      send_beat(CMD_INSERT, 64'h41, '1, 5'd1);
      send_beat(CMD_INSERT, 64'h41, '0, 5'd1);
      send_beat(CMD_LOOKUP, '1, '1, 5'd16);
      send_beat(CMD_LOOKUP, '1, '1, 5'd31);
      send_beat(CMD_LOOKUP, '0, '0, 5'd0);
      send_beat(CMD_LOOKUP, 64'h41, '0, 5'd2);
      send_beat(CMD_REMOVE, '0, '0, 5'd0);
      send_beat(CMD_REMOVE, '1, '1, 5'd16);
      send_beat(CMD_REMOVE, 64'h42, '0, 5'd1);
      send_beat(CMD_UNUSED, '1, '1, 5'd15);
      send_beat(CMD_REMOVE, 64'h41, '0, 5'd1);
      send_beat(CMD_REMOVE, '1, '1, 5'd15);
      // fill to the brim, overflow, then drain
      for (int i = 0; i < 41; i++)
         send_beat(CMD_INSERT, 64'(i + 1), 56'(i) << 8, 5'd15);
      send_beat(CMD_INSERT, '0, '1, 5'd12);
      send_beat(CMD_INSERT, 64'h5, '0, 5'd15);
      for (int i = 0; i < 40; i++)
         send_beat(CMD_REMOVE, 64'(i + 1), 56'(i) << 8, 5'd15);
      n = 0;
      while (n < 1250) begin
         if (n % 40 == 0)
            for (int k = 0; k < 12; k++) begin
               pool_lo[k] = {$urandom, $urandom};
               pool_hi[k] = 56'({$urandom, $urandom});
               pool_len[k] = (k < 2) ? 5'd15 : 5'($urandom_range(1, 15));
            end
         calm = (n >= 500 && n < 700);
         if ($urandom_range(99) < 85) begin
            send_pool($urandom_range(11));
         end else begin
            send_beat(2'($urandom), {$urandom, $urandom}, 56'({$urandom, $urandom}),
                      5'($urandom));
         end
         n++;
      end
      req_valid <= 1'b0;
      calm = 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire
